// ===== rtl/dpc_pkg.sv =====
// Shared types and constants for the dual event performance counter.
// No dependencies.
`default_nettype none

package dpc_pkg;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_WRITE = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    localparam logic [2:0] SEL_CTRL0   = 3'd0;
    localparam logic [2:0] SEL_CTRL1   = 3'd1;
    localparam logic [2:0] SEL_COUNT0H = 3'd2;
    localparam logic [2:0] SEL_COUNT0L = 3'd3;
    localparam logic [2:0] SEL_COUNT1H = 3'd4;
    localparam logic [2:0] SEL_COUNT1L = 3'd5;

    localparam int CTRL_W     = 16;
    localparam int PULSE_W    = 64;
    localparam int DATA_W     = 32;
    localparam int EN_BIT     = 15;
    localparam int START_BIT  = 14;
    localparam int CLEAR_BIT  = 13;

    // event codes 04 05 08 0a 0e 0f 13 14 21 22 23 24 25 28 29
    localparam logic [PULSE_W-1:0] MODELLED_EVENTS = 64'h0000_033E_0018_C530;

    typedef struct packed {
        logic              tick;
        logic              wr;
        logic [CTRL_W-1:0] data;
    } cnt_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/dpc_counter.sv =====
// One event counter: control word plus wrapping count.
// Depends on dpc_pkg.
`default_nettype none

module dpc_counter
    import dpc_pkg::*;
#(
    parameter int COUNT_WIDTH = 48
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire cnt_cmd_t               cmd,
    input  wire logic [PULSE_W-1:0]     pulses,
    output logic      [CTRL_W-1:0]      ctrl,
    output logic      [COUNT_WIDTH-1:0] count
);

    logic [CTRL_W-1:0]      ctrl_reg, ctrl_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [5:0]             code;
    logic                   hit;

    assign code = ctrl_reg[5:0];
    assign hit  = ctrl_reg[EN_BIT] & ctrl_reg[START_BIT]
                & MODELLED_EVENTS[code] & pulses[code];

    always_comb begin
        ctrl_next  = ctrl_reg;
        count_next = count_reg;
        if (cmd.wr) begin
            ctrl_next            = cmd.data;
            ctrl_next[CLEAR_BIT] = 1'b0;
            if (cmd.data[CLEAR_BIT]) begin
                count_next = '0;
            end
        end else if (cmd.tick && hit) begin
            count_next = count_reg + COUNT_WIDTH'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg  <= '0;
            count_reg <= '0;
        end else begin
            ctrl_reg  <= ctrl_next;
            count_reg <= count_next;
        end
    end

    assign ctrl  = ctrl_reg;
    assign count = count_reg;

    a_clear_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr && cmd.data[CLEAR_BIT] |=> count_reg == '0)
        else $error("count not cleared");

    a_no_clear_stored: assert property (@(posedge aclk) disable iff (!aresetn)
        !ctrl_reg[CLEAR_BIT])
        else $error("clear bit stored");

    a_count_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.tick && !cmd.wr |=> $stable(count_reg))
        else $error("count moved without command");

endmodule

`default_nettype wire

// ===== rtl/dual_event_performance_counter_top.sv =====
// Top level of the dual event performance counter: input register, two
// counters, read mux and result register. Depends on dpc_pkg, dpc_counter.
//
// Use: each s_ beat is a tick (s_mode 0, s_event_pulses), a register read
// (s_mode 1, s_reg_select) or a register write (s_mode 2, s_write_data).
// Only a read returns a beat on m_read_data; ticks and writes return none.
// Slots: 0/1 control words, 2/4 count high 16 bits, 3/5 count low 32 bits,
// 6/7 read zero. Writing bit 13 of a control word zeroes that count.
// Flow: an accepted beat is held in the input register and executed as it
// leaves it; a read result then goes to the result register and on to m_.
// Throughput: one beat per cycle, set by the single input register stage.
// A stalled read result holds in the result register; ticks and writes
// behind it keep flowing until another read meets the full result register,
// and then s_ready drops.
// Reset clears controls, counts and both valid flags.
`default_nettype none

module dual_event_performance_counter_top
    import dpc_pkg::*;
#(
    parameter int COUNT_WIDTH = 48
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [1:0]          s_mode,
    input  wire logic [2:0]          s_reg_select,
    input  wire logic [CTRL_W-1:0]   s_write_data,
    input  wire logic [PULSE_W-1:0]  s_event_pulses,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic      [DATA_W-1:0]   m_read_data
);

    logic                   in_valid_reg, in_valid_next;
    mode_t                  mode_reg;
    logic [2:0]             sel_reg;
    logic [CTRL_W-1:0]      data_reg;
    logic [PULSE_W-1:0]     pulses_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]      rdata_reg;
    logic [DATA_W-1:0]      rdata_next;
    logic                   advance;
    logic                   is_read;
    cnt_cmd_t               cmd0, cmd1;
    logic [CTRL_W-1:0]      ctrl0, ctrl1;
    logic [COUNT_WIDTH-1:0] count0, count1;
    logic [63:0]            ext0, ext1;

    assign is_read = (mode_reg == MODE_READ);
    assign advance = in_valid_reg && (!is_read || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign in_valid_next = (s_valid && s_ready) || (in_valid_reg && !advance);

    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        if (advance && is_read) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            mode_reg   <= mode_t'(s_mode);
            sel_reg    <= s_reg_select;
            data_reg   <= s_write_data;
            pulses_reg <= s_event_pulses;
        end
        if (advance && is_read) begin
            rdata_reg <= rdata_next;
        end
    end

    always_comb begin
        cmd0      = '0;
        cmd1      = '0;
        cmd0.data = data_reg;
        cmd1.data = data_reg;
        cmd0.tick = advance && (mode_reg == MODE_TICK);
        cmd1.tick = cmd0.tick;
        cmd0.wr   = advance && (mode_reg == MODE_WRITE) && (sel_reg == SEL_CTRL0);
        cmd1.wr   = advance && (mode_reg == MODE_WRITE) && (sel_reg == SEL_CTRL1);
    end

    dpc_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_cnt0 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd0),
        .pulses  (pulses_reg),
        .ctrl    (ctrl0),
        .count   (count0)
    );

    dpc_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_cnt1 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd1),
        .pulses  (pulses_reg),
        .ctrl    (ctrl1),
        .count   (count1)
    );

    assign ext0 = 64'(count0);
    assign ext1 = 64'(count1);

    always_comb begin
        case (sel_reg)
            SEL_CTRL0:   rdata_next = {16'b0, ctrl0};
            SEL_CTRL1:   rdata_next = {16'b0, ctrl1};
            SEL_COUNT0H: rdata_next = {16'b0, ext0[47:32]};
            SEL_COUNT0L: rdata_next = ext0[31:0];
            SEL_COUNT1H: rdata_next = {16'b0, ext1[47:32]};
            SEL_COUNT1L: rdata_next = ext1[31:0];
            default:     rdata_next = '0;
        endcase
    end

    assign m_valid     = out_valid_reg;
    assign m_read_data = rdata_reg;

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> out_valid_reg && $stable(rdata_reg))
        else $error("stalled result lost");

    a_busy_has_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && is_read && out_valid_reg)
        else $error("ready low without a blocked read");

    a_unused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && is_read && (sel_reg > SEL_COUNT1L)
        |=> rdata_reg == '0)
        else $error("unused slot read nonzero");

endmodule

`default_nettype wire
